// ===== hw/rtl/lrupr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared types and constants for the LRU page replacement table.
// ----------------------------------------------------------------------------
package lrupr_pkg;

    // field widths fixed by the interface
    localparam int PAGE_BITS    = 16;
    localparam int CFG_W        = 4;
    localparam int FRAME_OUT_W  = 3;
    localparam int FAULT_W      = 32;

    // frames_in_use after reset
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } lrupr_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd_issue;
        logic commit;
        logic cfg_wr;
    } lrupr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last_issue;
        logic out_free;
    } lrupr_sts_t;

endpackage

// ===== hw/rtl/lru_page_replacement.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_replacement
// LRU page replacement table: one page reference in, one placement result out.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_stall) carries page and last_reference; a request
//   is taken when in_valid is high and in_stall is low.
//   out channel (out_valid/out_stall) carries hit, frame_index, evicted_valid,
//   evicted_page, fault_count and final_result; the result register holds
//   its payload for as long as out_stall is high.
//   cfg channel (cfg_valid/cfg_ready, cfg_data) writes frames_in_use; a write
//   also empties every frame and clears the recency ranks, fault count kept.
// Sequencing:
//   a request walks the active frames one per cycle through the single read
//   port of the page memory, then passes the drain and commit states; a new
//   request is taken only once the controller is back in idle.
//   While the result waits on out_stall the next request is still taken and
//   scanned; its commit waits until the result register is free.
// Reset:
//   all frames empty, ranks zero, fault count zero, frames_in_use = 8.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
    parameter int FRAMES = 8
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic [lrupr_pkg::PAGE_BITS-1:0]          page,
    input  logic                                     last_reference,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic                                     hit,
    output logic [lrupr_pkg::FRAME_OUT_W-1:0]        frame_index,
    output logic                                     evicted_valid,
    output logic [lrupr_pkg::PAGE_BITS-1:0]          evicted_page,
    output logic [lrupr_pkg::FAULT_W-1:0]            fault_count,
    output logic                                     final_result,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [lrupr_pkg::CFG_W-1:0]              cfg_data
);
    import lrupr_pkg::*;

    lrupr_cmd_t cmd;
    lrupr_sts_t sts;

    // sequencer
    lrupr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // table and result register
    lrupr_datapath #(
        .FRAMES (FRAMES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_data       (cfg_data),
        .page           (page),
        .last_reference (last_reference),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hit            (hit),
        .frame_index    (frame_index),
        .evicted_valid  (evicted_valid),
        .evicted_page   (evicted_page),
        .fault_count    (fault_count),
        .final_result   (final_result)
    );

endmodule

// ===== hw/rtl/lrupr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_ctrl
// Sequencer for one request: frame scan, pipeline drain, table commit.
// ----------------------------------------------------------------------------
module lrupr_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  lrupr_pkg::lrupr_sts_t sts,
    output lrupr_pkg::lrupr_cmd_t cmd
);
    import lrupr_pkg::*;

    lrupr_state_t state_reg;
    lrupr_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !cfg_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall     = 1'b1;
        cfg_ready    = 1'b0;
        cmd.load     = 1'b0;
        cmd.rd_issue = 1'b0;
        cmd.commit   = 1'b0;
        cmd.cfg_wr   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cfg_ready  = 1'b1;
                cmd.cfg_wr = cfg_valid;
                in_stall   = cfg_valid;
                cmd.load   = in_valid && !cfg_valid;
            end
            ST_SCAN:
            begin
                cmd.rd_issue = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd.rd_issue = 1'b0;
            end
            ST_COMMIT:
            begin
                cmd.commit = sts.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== hw/rtl/lrupr_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrupr_datapath
// Page memory, valid bits, recency ranks, scan evaluation and result register.
// ----------------------------------------------------------------------------
module lrupr_datapath #(
    parameter int FRAMES = 8
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  lrupr_pkg::lrupr_cmd_t                    cmd,
    output lrupr_pkg::lrupr_sts_t                    sts,
    input  logic [lrupr_pkg::CFG_W-1:0]              cfg_data,
    input  logic [lrupr_pkg::PAGE_BITS-1:0]          page,
    input  logic                                     last_reference,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic                                     hit,
    output logic [lrupr_pkg::FRAME_OUT_W-1:0]        frame_index,
    output logic                                     evicted_valid,
    output logic [lrupr_pkg::PAGE_BITS-1:0]          evicted_page,
    output logic [lrupr_pkg::FAULT_W-1:0]            fault_count,
    output logic                                     final_result
);
    import lrupr_pkg::*;

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);

    // page memory, undefined until written
    logic [PAGE_BITS-1:0] mem [FRAMES];
    logic [PAGE_BITS-1:0] mem_q_reg;

    logic [FRAMES-1:0]    valid_reg;
    logic [IDX_W-1:0]     rank_reg [FRAMES];
    logic [CFG_W-1:0]     fiu_reg;
    logic [FAULT_W-1:0]   fault_reg;

    logic [PAGE_BITS-1:0] req_page_reg;
    logic                 req_last_reg;
    logic [IDX_W-1:0]     cnt_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    logic                 rd_pend_reg;

    logic                 hit_found_reg;
    logic [IDX_W-1:0]     hit_idx_reg;
    logic [IDX_W-1:0]     hit_rank_reg;
    logic                 empty_found_reg;
    logic [IDX_W-1:0]     empty_idx_reg;
    logic [IDX_W-1:0]     vic_idx_reg;
    logic [IDX_W-1:0]     vic_rank_reg;
    logic [PAGE_BITS-1:0] vic_page_reg;

    logic                   out_valid_reg;
    logic                   out_hit_reg;
    logic [FRAME_OUT_W-1:0] out_frame_reg;
    logic                   out_ev_valid_reg;
    logic [PAGE_BITS-1:0]   out_ev_page_reg;
    logic                   out_last_reg;

    logic [CNT_W-1:0]     n_active;
    logic                 ev_valid;
    logic                 ev_hit;
    logic                 ev_empty;
    logic                 ev_victim;
    logic [IDX_W-1:0]     sel_idx;
    logic [IDX_W-1:0]     sel_age;
    logic                 age_all;
    logic                 miss;
    logic [FAULT_W-1:0]   fault_next;

    // active frame count, clamped to 1..FRAMES
    always_comb
    begin
        if (fiu_reg == '0)
        begin
            n_active = CNT_W'(1);
        end
        else if (32'(fiu_reg) > FRAMES)
        begin
            n_active = CNT_W'(FRAMES);
        end
        else
        begin
            n_active = CNT_W'(fiu_reg);
        end
    end

    assign sts.last_issue = (CNT_W'(cnt_reg) + CNT_W'(1)) == n_active;
    assign sts.out_free   = !out_valid_reg || !out_stall;

    // scan read port
    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
        begin
            mem_q_reg <= mem[cnt_reg];
        end
        if (cmd.commit && miss)
        begin
            mem[sel_idx] <= req_page_reg;
        end
    end

    // evaluation of the entry returned by the memory
    assign ev_valid  = valid_reg[rd_idx_reg];
    assign ev_hit    = rd_pend_reg && ev_valid && (mem_q_reg == req_page_reg)
                       && !hit_found_reg;
    assign ev_empty  = rd_pend_reg && !ev_valid && !empty_found_reg;
    assign ev_victim = rd_pend_reg &&
                       ((rd_idx_reg == '0) || (rank_reg[rd_idx_reg] > vic_rank_reg));

    // request capture and scan bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg         <= '0;
            rd_pend_reg     <= 1'b0;
            hit_found_reg   <= 1'b0;
            empty_found_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= cmd.rd_issue;
            if (cmd.load)
            begin
                cnt_reg         <= '0;
                hit_found_reg   <= 1'b0;
                empty_found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.rd_issue)
                begin
                    cnt_reg <= cnt_reg + IDX_W'(1);
                end
                if (ev_hit)
                begin
                    hit_found_reg <= 1'b1;
                end
                if (ev_empty)
                begin
                    empty_found_reg <= 1'b1;
                end
            end
        end
    end

    // scan payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_page_reg <= page;
            req_last_reg <= last_reference;
        end
        if (cmd.rd_issue)
        begin
            rd_idx_reg <= cnt_reg;
        end
        if (ev_hit)
        begin
            hit_idx_reg  <= rd_idx_reg;
            hit_rank_reg <= rank_reg[rd_idx_reg];
        end
        if (ev_empty)
        begin
            empty_idx_reg <= rd_idx_reg;
        end
        if (ev_victim)
        begin
            vic_idx_reg  <= rd_idx_reg;
            vic_rank_reg <= rank_reg[rd_idx_reg];
            vic_page_reg <= mem_q_reg;
        end
    end

    // chosen frame and the age below which frames grow older
    always_comb
    begin
        miss    = !hit_found_reg;
        age_all = 1'b0;
        priority if (hit_found_reg)
        begin
            sel_idx = hit_idx_reg;
            sel_age = hit_rank_reg;
        end
        else if (empty_found_reg)
        begin
            sel_idx = empty_idx_reg;
            sel_age = '0;
            age_all = 1'b1;
        end
        else
        begin
            sel_idx = vic_idx_reg;
            sel_age = vic_rank_reg;
        end
    end

    // saturating fault count
    assign fault_next = (miss && (fault_reg != '1)) ? fault_reg + FAULT_W'(1) : fault_reg;

    // frame count register and fault counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fiu_reg   <= CFG_RESET;
            fault_reg <= '0;
        end
        else
        begin
            if (cmd.cfg_wr)
            begin
                fiu_reg <= cfg_data;
            end
            if (cmd.commit)
            begin
                fault_reg <= fault_next;
            end
        end
    end

    // per-frame valid bit and recency rank update
    for (genvar g = 0; g < FRAMES; g++)
    begin : g_frame
        logic ages;

        assign ages = (CNT_W'(g) < n_active) && (IDX_W'(g) != sel_idx) && valid_reg[g]
                      && (age_all || (rank_reg[g] < sel_age));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
                rank_reg[g]  <= '0;
            end
            else if (cmd.cfg_wr)
            begin
                valid_reg[g] <= 1'b0;
                rank_reg[g]  <= '0;
            end
            else if (cmd.commit)
            begin
                if (IDX_W'(g) == sel_idx)
                begin
                    valid_reg[g] <= 1'b1;
                    rank_reg[g]  <= '0;
                end
                else if (ages)
                begin
                    rank_reg[g] <= rank_reg[g] + IDX_W'(1);
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_hit_reg      <= hit_found_reg;
            out_frame_reg    <= FRAME_OUT_W'(sel_idx);
            out_ev_valid_reg <= miss && !empty_found_reg;
            out_ev_page_reg  <= (miss && !empty_found_reg) ? vic_page_reg : '0;
            out_last_reg     <= req_last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign hit           = out_hit_reg;
    assign frame_index   = out_frame_reg;
    assign evicted_valid = out_ev_valid_reg;
    assign evicted_page  = out_ev_page_reg;
    assign fault_count   = fault_reg;
    assign final_result  = out_last_reg;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LRU page replacement table. A short list of
// directed references and frame-count writes comes first, then random
// reference strings drawn from small working sets under several frame counts.
// Every result is compared field by field with a typed value or the frame table predictor.
// ----------------------------------------------------------------------------
module tb;

    import lrupr_pkg::*;

    localparam int FRAMES          = 8;
    localparam int DRAIN_CYCLES    = 16;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int NUM_PHASES      = 10;
    localparam int REFS_PER_PHASE  = 200;
    localparam int NUM_DIRECTED    = 29;
    localparam int IDLE_MAX [3]    = '{0, 3, 18};
    localparam logic [CFG_W-1:0] PHASE_FRAMES [6] = '{4'd8, 4'd1, 4'd2, 4'd15, 4'd0, 4'd7};

    // one placement result as seen on the output port
    typedef struct packed {
        logic                   hit;
        logic [FRAME_OUT_W-1:0] frame;
        logic                   ev_valid;
        logic [PAGE_BITS-1:0]   ev_page;
        logic [FAULT_W-1:0]     faults;
        logic                   final_ref;
    } placement_t;

    typedef enum logic {
        ROW_REF,
        ROW_CFG
    } row_kind_t;

    // directed row: a page reference or a frame-count write
    typedef struct packed {
        row_kind_t            kind;
        logic [PAGE_BITS-1:0] pg;
        logic                 last;
        logic [CFG_W-1:0]     frames;
        logic                 checked;
        placement_t           want;
    } stim_row_t;

    localparam placement_t NONE = '0;

    localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
        // empty table after reset, eight frames
        '{ROW_REF, 16'h0000, 1'b0, 4'd0, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 32'd1, 1'b0}},
        '{ROW_REF, 16'hFFFF, 1'b1, 4'd0, 1'b1, '{1'b0, 3'd1, 1'b0, 16'h0000, 32'd2, 1'b1}},
        '{ROW_REF, 16'h0000, 1'b0, 4'd0, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 32'd2, 1'b0}},
        '{ROW_REF, 16'h8001, 1'b0, 4'd0, 1'b0, NONE},
        // single frame: every new page replaces the last one
        '{ROW_CFG, 16'h0000, 1'b0, 4'd1, 1'b0, NONE},
        '{ROW_REF, 16'h1234, 1'b0, 4'd0, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 32'd4, 1'b0}},
        '{ROW_REF, 16'h5678, 1'b0, 4'd0, 1'b1, '{1'b0, 3'd0, 1'b1, 16'h1234, 32'd5, 1'b0}},
        '{ROW_REF, 16'h5678, 1'b1, 4'd0, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 32'd5, 1'b1}},
        // zero frames behaves as one
        '{ROW_CFG, 16'h0000, 1'b0, 4'd0, 1'b0, NONE},
        '{ROW_REF, 16'hAAAA, 1'b0, 4'd0, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 32'd6, 1'b0}},
        '{ROW_REF, 16'h5555, 1'b0, 4'd0, 1'b1, '{1'b0, 3'd0, 1'b1, 16'hAAAA, 32'd7, 1'b0}},
        // count above the table size behaves as eight
        '{ROW_CFG, 16'h0000, 1'b0, 4'd15, 1'b0, NONE},
        '{ROW_REF, 16'h0010, 1'b0, 4'd0, 1'b0, NONE},
        '{ROW_REF, 16'h0011, 1'b0, 4'd0, 1'b0, NONE},
        '{ROW_REF, 16'h0012, 1'b0, 4'd0, 1'b0, NONE},
        '{ROW_REF, 16'h0013, 1'b0, 4'd0, 1'b0, NONE},
        '{ROW_REF, 16'h0014, 1'b0, 4'd0, 1'b0, NONE},
        '{ROW_REF, 16'h0015, 1'b0, 4'd0, 1'b0, NONE},
        '{ROW_REF, 16'h0016, 1'b0, 4'd0, 1'b0, NONE},
        '{ROW_REF, 16'h0017, 1'b1, 4'd0, 1'b0, NONE},
        '{ROW_REF, 16'h0010, 1'b0, 4'd0, 1'b0, NONE},
        '{ROW_REF, 16'h0020, 1'b0, 4'd0, 1'b0, NONE},
        // three frames, hit reorders the victim choice
        '{ROW_CFG, 16'h0000, 1'b0, 4'd3, 1'b0, NONE},
        '{ROW_REF, 16'h0001, 1'b0, 4'd0, 1'b0, NONE},
        '{ROW_REF, 16'h0002, 1'b0, 4'd0, 1'b0, NONE},
        '{ROW_REF, 16'h0003, 1'b0, 4'd0, 1'b0, NONE},
        '{ROW_REF, 16'h0002, 1'b0, 4'd0, 1'b0, NONE},
        '{ROW_REF, 16'h0004, 1'b0, 4'd0, 1'b0, NONE},
        '{ROW_REF, 16'h0005, 1'b1, 4'd0, 1'b0, NONE}
    };

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [PAGE_BITS-1:0]   page;
    logic                   last_reference;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   hit;
    logic [FRAME_OUT_W-1:0] frame_index;
    logic                   evicted_valid;
    logic [PAGE_BITS-1:0]   evicted_page;
    logic [FAULT_W-1:0]     fault_count;
    logic                   final_result;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_W-1:0]       cfg_data;

    // predictor copy of the frame table
    logic [PAGE_BITS-1:0]   frame_page [FRAMES];
    logic                   resident [FRAMES];
    int                     frame_rank [FRAMES];
    logic [FAULT_W-1:0]     fault_total = '0;
    logic [CFG_W-1:0]       frames_cfg = CFG_RESET;

    placement_t             pending_placements [$];
    int                     mismatches = 0;
    int                     quiet_cycles = 0;
    int                     src_max = 0;
    int                     sink_max = 0;
    int                     sink_left = 0;

    lru_page_replacement dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .page           (page),
        .last_reference (last_reference),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hit            (hit),
        .frame_index    (frame_index),
        .evicted_valid  (evicted_valid),
        .evicted_page   (evicted_page),
        .fault_count    (fault_count),
        .final_result   (final_result),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always #6 clk = ~clk;

    // out-of-range frame counts clamp to 1..FRAMES
    function automatic int effective_frames(input logic [CFG_W-1:0] value);
        if (value == 0)
            return 1;
        if (value > FRAMES)
            return FRAMES;
        return int'(value);
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < FRAMES; i++)
        begin
            frame_page[i] = '0;
            resident[i]   = 1'b0;
            frame_rank[i] = 0;
        end
    endfunction

    // make one frame most recent, age the younger resident frames
    function automatic void age_frames(input int n, input int slot, input int age);
        for (int g = 0; g < n; g++)
        begin
            if (g != slot && resident[g] && frame_rank[g] < age)
                frame_rank[g]++;
        end
        frame_rank[slot] = 0;
    endfunction

    // look up one page reference and update the table
    function automatic placement_t place_page(input logic [PAGE_BITS-1:0] pg, input logic last);
        placement_t res;
        int         n;
        int         slot;
        int         oldest;
        logic       found;
        res    = '0;
        n      = effective_frames(frames_cfg);
        slot   = 0;
        found  = 1'b0;
        // first matching resident frame from index 0 up
        for (int j = 0; j < n; j++)
        begin
            if (!found && resident[j] && frame_page[j] == pg)
            begin
                found = 1'b1;
                slot  = j;
            end
        end
        if (found)
        begin
            res.hit = 1'b1;
            age_frames(n, slot, frame_rank[slot]);
        end
        else
        begin
            // lowest empty frame, else the oldest, lowest index on a tie
            for (int j = 0; j < n; j++)
            begin
                if (!found && !resident[j])
                begin
                    found = 1'b1;
                    slot  = j;
                end
            end
            if (found)
            begin
                resident[slot]   = 1'b1;
                frame_page[slot] = pg;
                age_frames(n, slot, FRAMES);
            end
            else
            begin
                slot   = 0;
                oldest = frame_rank[0];
                for (int j = 1; j < n; j++)
                begin
                    if (frame_rank[j] > oldest)
                    begin
                        oldest = frame_rank[j];
                        slot   = j;
                    end
                end
                res.ev_valid     = 1'b1;
                res.ev_page      = frame_page[slot];
                frame_page[slot] = pg;
                age_frames(n, slot, oldest);
            end
            if (fault_total != '1)
                fault_total++;
        end
        res.frame     = FRAME_OUT_W'(slot);
        res.faults    = fault_total;
        res.final_ref = last;
        return res;
    endfunction

    // send one request and queue what it should produce
    task automatic send_ref(input logic [PAGE_BITS-1:0] pg, input logic last,
                            input logic use_typed, input placement_t typed);
        int         gap;
        placement_t predicted;
        gap = $urandom_range(0, src_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        page           <= pg;
        last_reference <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = place_page(pg, last);
        pending_placements.push_back(use_typed ? typed : predicted);
    endtask

    // frame-count write once the table has gone quiet
    task automatic write_frames(input logic [CFG_W-1:0] value);
        in_valid <= 1'b0;
        while (pending_placements.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        frames_cfg  = value;
        clear_table();
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            mismatches++;
            $display("%0t: %s expected %0h got %0h", $time, name, want_v, got_v);
        end
    endtask

    // result checking, receiver stalls and watchdog
    always @(posedge clk)
    begin
        placement_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_placements.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with no request outstanding, expected none got frame %0d",
                         $time, frame_index);
            end
            else
            begin
                want = pending_placements.pop_front();
                check_field("hit", 32'(want.hit), 32'(hit));
                check_field("frame_index", 32'(want.frame), 32'(frame_index));
                check_field("evicted_valid", 32'(want.ev_valid), 32'(evicted_valid));
                check_field("evicted_page", 32'(want.ev_page), 32'(evicted_page));
                check_field("fault_count", want.faults, fault_count);
                check_field("final_result", 32'(want.final_ref), 32'(final_result));
            end
            sink_left = $urandom_range(0, sink_max);
        end
        else if (sink_left > 0)
        begin
            sink_left = sink_left - 1;
        end
        out_stall <= (sink_left != 0);

        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        logic [PAGE_BITS-1:0] pool [12];
        logic [PAGE_BITS-1:0] pg;
        logic                 last;
        logic [CFG_W-1:0]     next_frames;
        int                   pool_n;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        page           = '0;
        last_reference = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        clear_table();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows
        src_max  = 5;
        sink_max = 5;
        for (int r = 0; r < NUM_DIRECTED; r++)
        begin
            if (DIRECTED[r].kind == ROW_CFG)
                write_frames(DIRECTED[r].frames);
            else
                send_ref(DIRECTED[r].pg, DIRECTED[r].last, DIRECTED[r].checked,
                         DIRECTED[r].want);
        end

        // random reference strings, one frame count per phase
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            next_frames = (phase < 6) ? PHASE_FRAMES[phase] : CFG_W'($urandom_range(0, 15));
            write_frames(next_frames);
            pool_n = effective_frames(next_frames) + $urandom_range(0, 3);
            for (int k = 0; k < pool_n; k++)
                pool[k] = PAGE_BITS'($urandom);
            if (phase == 0)
            begin
                src_max  = 0;
                sink_max = 0;
            end
            else if (phase == 1)
            begin
                src_max  = IDLE_MAX[2];
                sink_max = IDLE_MAX[2];
            end
            else
            begin
                src_max  = IDLE_MAX[$urandom_range(0, 2)];
                sink_max = IDLE_MAX[$urandom_range(0, 2)];
            end
            for (int k = 0; k < REFS_PER_PHASE; k++)
            begin
                // mostly a small working set, some stray pages
                if ($urandom_range(0, 99) < 85)
                    pg = pool[$urandom_range(0, pool_n - 1)];
                else
                    pg = PAGE_BITS'($urandom);
                last = (k == REFS_PER_PHASE - 1) || ($urandom_range(0, 19) == 0);
                send_ref(pg, last, 1'b0, NONE);
            end
        end

        // drain and report
        in_valid <= 1'b0;
        while (pending_placements.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_placements.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
